// File: rtl/vnu_pkg.sv
// Shared types, constants and rounding helpers for the Verlet node update block.
package vnu_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_PIN    = 2'd2,
    CMD_UPDATE = 2'd3
  } vnu_cmd_t;

  localparam logic [2:0] CFG_DRAG       = 3'd0;
  localparam logic [2:0] CFG_TIME_STEP  = 3'd1;
  localparam logic [2:0] CFG_GRAVITY_X  = 3'd2;
  localparam logic [2:0] CFG_GRAVITY_Y  = 3'd3;
  localparam logic [2:0] CFG_BOX_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_BOX_HEIGHT = 3'd5;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned MUL_W  = 26;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Selection radius of 2000 square pixels, in Q.16 square units.
  localparam logic signed [PROD_W-1:0] SEL_LIMIT  = 52'sd131072000;
  // 0.1 in Q0.16.
  localparam logic signed [MUL_W-1:0]  NUDGE_GAIN = 26'sd6554;

  localparam logic [3:0] STEP_FIRST = 4'd1;
  localparam logic [3:0] STEP_LAST  = 4'd11;

  typedef struct packed {
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic signed [POS_W-1:0] prev_x;
    logic signed [POS_W-1:0] prev_y;
    logic signed [POS_W-1:0] home_x;
    logic signed [POS_W-1:0] home_y;
    logic                    pinned;
  } vnu_entry_t;

  // Round to nearest with ties toward plus infinity, drop 16 fraction bits.
  function automatic logic signed [31:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = (p + 52'sd32768) >>> 16;
    return signed'(q[31:0]);
  endfunction

  function automatic logic signed [POS_W-1:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sh7FFFFF;
    if (v < -32'sd8388608) return 24'sh800000;
    return v[POS_W-1:0];
  endfunction

endpackage

// File: rtl/verlet_node_update_top.sv
// Top level of the Verlet node update block: node table, shared multiplier and sequencer.
//
//   Channel  Direction  Handshake             Contents
//   in_      slave      in_tvalid/in_tready   one command item addressed to one node
//   out_     master     out_tvalid/out_tready one result item per command item
//   cfg_     write      cfg_we                damping, step, gravity and box registers
//
// An update item passes from acceptance through the table read, the sequencer steps over
// the single 26 x 26 signed multiplier (one product a cycle, each product registered and
// used by the following steps) and write-back. Load, set and pin items and items whose
// node lies beyond NODE_COUNT go from the table read straight to write-back.
// The block is ready again in the cycle after write-back, so a new item is accepted only
// once the previous one has left write-back.
// rst_n is synchronous and active low; it clears control state and loads the register
// reset values, while the node table stays undefined until each entry is loaded.
// A result waiting in the output register does not hold off the next item; only the
// write-back of the following item waits until that result has been taken.
module verlet_node_update_top #(
  parameter int NODE_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata from bit 0: node[7:0], coord_x[31:8], coord_y[55:32], mouse_x[71:56],
  // mouse_y[87:72], left_button[88], right_button[89], zero fill [95:90].
  input  logic [95:0]           in_tdata,
  // tuser: command[1:0].
  input  logic [1:0]            in_tuser,
  // Result item.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata from bit 0: node_out[7:0], pos_x[31:8], pos_y[55:32], selected[56],
  // disconnect[57], zero fill [63:58].
  output logic [63:0]           out_tdata,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [23:0]           cfg_wdata
);
  import vnu_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_WB
  } state_t;

  // Configuration registers.
  logic [15:0]             drag_r, time_step_r, box_width_r, box_height_r;
  logic signed [POS_W-1:0] gravity_x_r, gravity_y_r;

  // Captured item.
  vnu_cmd_t                cmd_r;
  logic [7:0]              node_r;
  logic signed [POS_W-1:0] coord_x_r, coord_y_r;
  logic signed [15:0]      mouse_x_r, mouse_y_r;
  logic                    left_r, right_r;
  logic                    in_range_r;

  // Sequencer and datapath registers.
  state_t                  state_r;
  logic [3:0]              step_r;
  logic [AW-1:0]           addr_r;
  vnu_entry_t              rdata_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic                    sel_r;
  logic signed [17:0]      t_r;
  logic signed [POS_W-1:0] px_r, py_r, nx_r, ny_r;
  logic signed [31:0]      sum_r;

  // Result register.
  logic                    out_tvalid_r;
  logic [7:0]              node_out_r;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r;
  logic                    selected_r, disconnect_r;

  // Node table.
  vnu_entry_t              mem [NODE_COUNT];
  logic                    mem_we;
  vnu_entry_t              wdata;

  // Combinational datapath.
  logic signed [24:0]      dx, dy, vel_x, vel_y;
  logic signed [17:0]      decay;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [31:0]      rp;
  logic                    out_free;
  logic                    in_accept;
  logic signed [31:0]      wall, floor3, nx_ext, ny_ext;
  logic signed [POS_W-1:0] res_x, res_y;
  logic                    res_disc;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign dx    = {rdata_r.cur_x[POS_W-1], rdata_r.cur_x} - {mouse_x_r[15], mouse_x_r, 8'd0};
  assign dy    = {rdata_r.cur_y[POS_W-1], rdata_r.cur_y} - {mouse_y_r[15], mouse_y_r, 8'd0};
  assign vel_x = {rdata_r.cur_x[POS_W-1], rdata_r.cur_x} - {px_r[POS_W-1], px_r};
  assign vel_y = {rdata_r.cur_y[POS_W-1], rdata_r.cur_y} - {py_r[POS_W-1], py_r};
  assign decay = 18'sd65536 - signed'({2'b00, drag_r});
  assign rp    = rnd16(prod_r);

  // Operand selection for the shared multiplier, one product per sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      4'd1: begin mul_a = {dx[24], dx}; mul_b = {dx[24], dx}; end
      4'd2: begin mul_a = {dy[24], dy}; mul_b = {dy[24], dy}; end
      4'd3: begin mul_a = {10'd0, time_step_r}; mul_b = {10'd0, time_step_r}; end
      4'd4: begin mul_a = {dx[24], dx}; mul_b = NUDGE_GAIN; end
      4'd5: begin mul_a = {dy[24], dy}; mul_b = NUDGE_GAIN; end
      4'd6: begin mul_a = {{8{decay[17]}}, decay}; mul_b = {{8{t_r[17]}}, t_r}; end
      4'd7: begin mul_a = {vel_x[24], vel_x}; mul_b = {{8{decay[17]}}, decay}; end
      4'd8: begin mul_a = {{2{gravity_x_r[POS_W-1]}}, gravity_x_r};
                  mul_b = {{8{t_r[17]}}, t_r}; end
      4'd9: begin mul_a = {vel_y[24], vel_y}; mul_b = {{8{decay[17]}}, decay}; end
      4'd10: begin mul_a = {{2{gravity_y_r[POS_W-1]}}, gravity_y_r};
                   mul_b = {{8{t_r[17]}}, t_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Box limits: the right wall and three times the floor height, in Q.8.
  assign wall   = signed'({8'd0, box_width_r, 8'd0});
  assign floor3 = signed'({6'd0, ({2'b00, box_height_r} + {1'b0, box_height_r, 1'b0}), 8'd0});
  assign nx_ext = 32'(nx_r);
  assign ny_ext = 32'(ny_r);

  // Write-back entry and result, chosen by command.
  always_comb begin
    wdata    = rdata_r;
    res_x    = rdata_r.cur_x;
    res_y    = rdata_r.cur_y;
    res_disc = 1'b0;
    unique case (cmd_r)
      CMD_LOAD: begin
        wdata.cur_x  = coord_x_r;
        wdata.prev_x = coord_x_r;
        wdata.home_x = coord_x_r;
        wdata.cur_y  = coord_y_r;
        wdata.prev_y = coord_y_r;
        wdata.home_y = coord_y_r;
        wdata.pinned = 1'b0;
      end
      CMD_SET: begin
        wdata.cur_x = coord_x_r;
        wdata.cur_y = coord_y_r;
      end
      CMD_PIN: begin
        wdata.pinned = 1'b1;
      end
      CMD_UPDATE: begin
        res_disc = right_r && sel_r;
        if (rdata_r.pinned) begin
          // A pinned node snaps home; the nudged previous position is kept.
          wdata.cur_x  = rdata_r.home_x;
          wdata.cur_y  = rdata_r.home_y;
          wdata.prev_x = px_r;
          wdata.prev_y = py_r;
        end else begin
          wdata.prev_x = rdata_r.cur_x;
          wdata.prev_y = rdata_r.cur_y;
          wdata.cur_x  = nx_r;
          wdata.cur_y  = ny_r;
          if (nx_ext > wall) begin
            wdata.cur_x  = wall[POS_W-1:0];
            wdata.prev_x = wall[POS_W-1:0];
          end else if (nx_r < 0) begin
            wdata.cur_x  = '0;
            wdata.prev_x = '0;
          end
          if (ny_ext > floor3) begin
            res_disc = 1'b1;
          end else if (ny_r < 0) begin
            wdata.cur_y  = '0;
            wdata.prev_y = '0;
          end
        end
      end
      default: wdata = rdata_r;
    endcase
    if (cmd_r != CMD_PIN) begin
      res_x = wdata.cur_x;
      res_y = wdata.cur_y;
    end
  end

  assign mem_we = (state_r == ST_WB) && out_free && in_range_r;

  // Node table: one write port, one registered read port, no reset.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= wdata;
    end
    if (state_r == ST_READ) begin
      rdata_r <= mem[addr_r];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_r       <= 16'd655;
      time_step_r  <= 16'd1092;
      gravity_x_r  <= 24'sd0;
      gravity_y_r  <= 24'sd256000;
      box_width_r  <= 16'd800;
      box_height_r <= 16'd600;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DRAG:       drag_r       <= cfg_wdata[15:0];
        CFG_TIME_STEP:  time_step_r  <= cfg_wdata[15:0];
        CFG_GRAVITY_X:  gravity_x_r  <= signed'(cfg_wdata);
        CFG_GRAVITY_Y:  gravity_y_r  <= signed'(cfg_wdata);
        CFG_BOX_WIDTH:  box_width_r  <= cfg_wdata[15:0];
        CFG_BOX_HEIGHT: box_height_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier with its product register.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer, datapath registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // In write-back the result register is loaded below whenever it is free.
      if (out_tvalid_r && out_tready && state_r != ST_WB) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cmd_r      <= vnu_cmd_t'(in_tuser);
            node_r     <= in_tdata[7:0];
            addr_r     <= AW'(in_tdata[7:0]);
            in_range_r <= (32'(in_tdata[7:0]) < NODE_COUNT);
            coord_x_r  <= signed'(in_tdata[31:8]);
            coord_y_r  <= signed'(in_tdata[55:32]);
            mouse_x_r  <= signed'(in_tdata[71:56]);
            mouse_y_r  <= signed'(in_tdata[87:72]);
            left_r     <= in_tdata[88];
            right_r    <= in_tdata[89];
            sel_r      <= 1'b0;
            state_r    <= ST_READ;
          end
        end
        ST_READ: begin
          if (in_range_r && cmd_r == CMD_UPDATE) begin
            step_r  <= STEP_FIRST;
            state_r <= ST_CALC;
          end else begin
            state_r <= ST_WB;
          end
        end
        ST_CALC: begin
          case (step_r)
            4'd1: begin
              px_r <= rdata_r.prev_x;
              py_r <= rdata_r.prev_y;
            end
            4'd2: acc_r <= prod_r;
            4'd3: sel_r <= ((acc_r + prod_r) < SEL_LIMIT);
            4'd4: t_r <= rp[17:0];
            4'd5: if (left_r && sel_r) px_r <= sat24(32'(px_r) - rp);
            4'd6: if (left_r && sel_r) py_r <= sat24(32'(py_r) - rp);
            4'd7: t_r <= rp[17:0];
            4'd8: sum_r <= 32'(rdata_r.cur_x) + rp;
            4'd9: nx_r <= sat24(sum_r + rp);
            4'd10: sum_r <= 32'(rdata_r.cur_y) + rp;
            4'd11: ny_r <= sat24(sum_r + rp);
            default: ;
          endcase
          if (step_r == STEP_LAST) begin
            step_r  <= '0;
            state_r <= ST_WB;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        ST_WB: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            node_out_r   <= node_r;
            if (in_range_r) begin
              pos_x_r      <= res_x;
              pos_y_r      <= res_y;
              selected_r   <= (cmd_r == CMD_UPDATE) && sel_r;
              disconnect_r <= (cmd_r == CMD_UPDATE) && res_disc;
            end else begin
              pos_x_r      <= '0;
              pos_y_r      <= '0;
              selected_r   <= 1'b0;
              disconnect_r <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, disconnect_r, selected_r, pos_y_r, pos_x_r, node_out_r};

`ifndef SYNTH
  // An accepted item always goes to the table read next.
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_READ))
    else $error("accepted item did not start a table read");

  // The step counter stays inside its range while the multiplier sequence runs.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (step_r >= STEP_FIRST && step_r <= STEP_LAST))
    else $error("sequencer step out of range");

  // Leaving write-back always presents a result.
  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && out_free) |=> (out_tvalid_r && state_r == ST_IDLE))
    else $error("write-back finished without a result");

  // A result never flags selection for a node outside the table.
  a_range_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && out_free && !in_range_r) |=> (!selected_r && !disconnect_r))
    else $error("out of range node produced flags");
`endif

endmodule

// File: test/tb_verlet_node_update_top.sv
// Self-checking testbench for the Verlet node update block with its own position predictor.
`timescale 1ns / 100ps

// Every command item sent to the block produces exactly one result item, in order.
// The testbench keeps its own copy of the node table and of the six settings
// registers. At the moment an item is accepted it works out the node state that
// the block should report, and it queues that expected result. The monitor pops
// the oldest expected result for every result item taken from the block and
// compares it field by field.
//
// The run is split into phases. The first phase runs a short directed table under
// the reset settings. It covers every command and both ends of the coordinate and
// cursor ranges. It also covers the left and right walls, the fall past the floor,
// a pinned node returning home, the cursor nudge, and saturation of the previous
// position. The later phases rewrite all registers while the block is idle and
// send random items. These include the extreme settings and zero box sizes.
// A command other than load is only ever aimed at a node that has been loaded,
// so the block never reports a table entry that was never written.
module tb_verlet_node_update_top;
  import vnu_pkg::*;

  localparam int     NODE_TOTAL    = 256;
  // Margin after the last result before the settings are rewritten or the run ends.
  localparam int     SETTLE_CYCLES = 20;
  localparam int     CYCLE_LIMIT   = 200000;
  localparam longint SEL_RADIUS2   = 64'sd131072000;  // 2000 px^2 in Q.16
  localparam longint NUDGE_GAIN_Q  = 64'sd6554;       // 0.1 in Q0.16

  localparam logic signed [23:0] POS_TOP   = 24'sh7FFFFF;
  localparam logic signed [23:0] POS_BOT   = 24'sh800000;
  localparam logic signed [15:0] MOUSE_TOP = 16'sh7FFF;
  localparam logic signed [15:0] MOUSE_BOT = 16'sh8000;

  // One command item as the block sees it.
  typedef struct packed {
    vnu_cmd_t           cmd;
    logic [7:0]         node;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic               left;
    logic               right;
  } node_cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0]         node;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               sel;
    logic               disc;
  } node_result_t;

  // A directed row. Where typed is set, want is the result read straight off the
  // rules; otherwise the predictor decides.
  typedef struct packed {
    node_cmd_t    item;
    logic         typed;
    node_result_t want;
  } directed_row_t;

  // Positions below are Q16.8: 25600 is 100 px, 102400 is 400 px, 76800 is 300 px,
  // and 460800 is 1800 px, which is exactly three times the reset box height.
  localparam directed_row_t DIRECTED_ROWS [23] = '{
    // A node at the origin. The cursor sits on it, so the update is selected.
    '{'{CMD_LOAD, 8'd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd0, 24'sd0, 24'sd0, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd0, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}, 1'b0, '0},
    // The top node at the far corner. It is pinned, so an update keeps it at home.
    // The cursor at the range limits lands within a fraction of a pixel of it,
    // so a right press disconnects it.
    '{'{CMD_LOAD, 8'd255, POS_TOP, POS_BOT, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd255, POS_TOP, POS_BOT, 1'b0, 1'b0}},
    '{'{CMD_PIN, 8'd255, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd255, POS_TOP, POS_BOT, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd255, 24'sd0, 24'sd0, MOUSE_TOP, MOUSE_BOT, 1'b0, 1'b1},
      1'b1, '{8'd255, POS_TOP, POS_BOT, 1'b1, 1'b1}},
    // A set after a load gives the node a velocity. The next update carries it on.
    '{'{CMD_LOAD, 8'd1, 24'sd25600, 24'sd25600, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd1, 24'sd25600, 24'sd25600, 1'b0, 1'b0}},
    '{'{CMD_SET, 8'd1, 24'sd51200, 24'sd38400, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd1, 24'sd51200, 24'sd38400, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd1, 24'sd0, 24'sd0, MOUSE_BOT, MOUSE_TOP, 1'b0, 1'b0}, 1'b0, '0},
    // The cursor sits exactly on the node and both buttons are held.
    '{'{CMD_LOAD, 8'd2, 24'sd102400, 24'sd76800, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd2, 24'sd102400, 24'sd76800, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd2, 24'sd0, 24'sd0, 16'sd400, 16'sd300, 1'b1, 1'b1}, 1'b0, '0},
    // The cursor is just off the node, so the left press nudges it. The node is then
    // pinned, and a further nudge must not stop it from returning home.
    '{'{CMD_LOAD, 8'd3, 24'sd102400, 24'sd76800, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd3, 24'sd102400, 24'sd76800, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd3, 24'sd0, 24'sd0, 16'sd410, 16'sd310, 1'b1, 1'b0}, 1'b0, '0},
    '{'{CMD_PIN, 8'd3, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CMD_UPDATE, 8'd3, 24'sd0, 24'sd0, 16'sd410, 16'sd310, 1'b1, 1'b0}, 1'b0, '0},
    // The node starts beyond the right wall and is clamped back onto it.
    '{'{CMD_LOAD, 8'd4, POS_TOP, 24'sd25600, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd4, POS_TOP, 24'sd25600, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd4, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}, 1'b0, '0},
    // The node starts at the most negative corner. Gravity adds only 70 LSB, so
    // both axes are clamped to zero.
    '{'{CMD_LOAD, 8'd5, POS_BOT, POS_BOT, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd5, POS_BOT, POS_BOT, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd5, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd5, 24'sd0, 24'sd0, 1'b0, 1'b0}},
    // The node rests exactly on the floor limit. The reset gravity moves it 70 LSB
    // past the limit, so it falls through and asks for a disconnect.
    '{'{CMD_LOAD, 8'd6, 24'sd25600, 24'sd460800, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd6, 24'sd25600, 24'sd460800, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd6, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd6, 24'sd25600, 24'sd460870, 1'b0, 1'b1}},
    // The previous position sits at the negative limit. The nudge pushes it further
    // down, so it saturates.
    '{'{CMD_LOAD, 8'd8, POS_BOT, POS_BOT, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd8, POS_BOT, POS_BOT, 1'b0, 1'b0}},
    '{'{CMD_SET, 8'd8, 24'sh800A00, 24'sh800A00, 16'sd0, 16'sd0, 1'b0, 1'b0},
      1'b1, '{8'd8, 24'sh800A00, 24'sh800A00, 1'b0, 1'b0}},
    '{'{CMD_UPDATE, 8'd8, 24'sd0, 24'sd0, MOUSE_BOT, MOUSE_BOT, 1'b1, 1'b0}, 1'b0, '0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [63:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [23:0] cfg_wdata  = '0;

  // The predictor's copy of the settings registers, starting from their reset values.
  logic [15:0]        drag_q16 = 16'd655;
  logic [15:0]        step_q16 = 16'd1092;
  logic signed [23:0] grav_x   = 24'sd0;
  logic signed [23:0] grav_y   = 24'sd256000;
  logic [15:0]        box_w    = 16'd800;
  logic [15:0]        box_h    = 16'd600;

  // The predictor's copy of the node table, plus a record of which nodes were loaded.
  logic signed [23:0] node_cur_x  [NODE_TOTAL];
  logic signed [23:0] node_cur_y  [NODE_TOTAL];
  logic signed [23:0] node_prev_x [NODE_TOTAL];
  logic signed [23:0] node_prev_y [NODE_TOTAL];
  logic signed [23:0] node_home_x [NODE_TOTAL];
  logic signed [23:0] node_home_y [NODE_TOTAL];
  logic               node_pinned [NODE_TOTAL];
  bit                 node_loaded [NODE_TOTAL];

  node_result_t node_results_due[$];
  int           fail_count  = 0;
  int           cycle_count = 0;
  int           stall_left  = 0;
  bit           idle_on     = 1'b0;

  verlet_node_update_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Round to nearest with ties going up, and drop 16 fraction bits.
  function automatic longint round_q16(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [23:0] clamp_pos(input longint v);
    if (v > longint'(POS_TOP)) return POS_TOP;
    if (v < longint'(POS_BOT)) return POS_BOT;
    return v[23:0];
  endfunction

  // Apply one command to the table copy and return the result the block should report.
  function automatic node_result_t integrate_node(input node_cmd_t item);
    node_result_t res;
    longint       cx0, cy0, dx, dy, decay, dt2, k, nx, ny, wall, floor3;
    int           n;
    n = item.node;
    res = '0;
    res.node = item.node;
    if (n >= NODE_TOTAL) return res;
    case (item.cmd)
      CMD_LOAD: begin
        node_cur_x[n]  = item.cx;
        node_prev_x[n] = item.cx;
        node_home_x[n] = item.cx;
        node_cur_y[n]  = item.cy;
        node_prev_y[n] = item.cy;
        node_home_y[n] = item.cy;
        node_pinned[n] = 1'b0;
        node_loaded[n] = 1'b1;
      end
      CMD_SET: begin
        node_cur_x[n] = item.cx;
        node_cur_y[n] = item.cy;
      end
      CMD_PIN: begin
        node_pinned[n] = 1'b1;
      end
      default: begin
        // The cursor test works in Q.8, so the squared distance is in Q.16.
        cx0 = longint'(node_cur_x[n]);
        cy0 = longint'(node_cur_y[n]);
        dx = cx0 - longint'(item.mx) * 256;
        dy = cy0 - longint'(item.my) * 256;
        res.sel = (dx * dx + dy * dy) < SEL_RADIUS2;
        if (item.left && res.sel) begin
          node_prev_x[n] = clamp_pos(longint'(node_prev_x[n]) - round_q16(dx * NUDGE_GAIN_Q));
          node_prev_y[n] = clamp_pos(longint'(node_prev_y[n]) - round_q16(dy * NUDGE_GAIN_Q));
        end
        res.disc = item.right && res.sel;
        if (node_pinned[n]) begin
          node_cur_x[n] = node_home_x[n];
          node_cur_y[n] = node_home_y[n];
        end else begin
          decay  = 64'sd65536 - longint'(drag_q16);
          dt2    = round_q16(longint'(step_q16) * longint'(step_q16));
          k      = round_q16(decay * dt2);
          nx = clamp_pos(cx0 + round_q16((cx0 - longint'(node_prev_x[n])) * decay)
                         + round_q16(longint'(grav_x) * k));
          ny = clamp_pos(cy0 + round_q16((cy0 - longint'(node_prev_y[n])) * decay)
                         + round_q16(longint'(grav_y) * k));
          wall   = longint'(box_w) * 256;
          floor3 = longint'(box_h) * 768;
          node_prev_x[n] = node_cur_x[n];
          node_prev_y[n] = node_cur_y[n];
          node_cur_x[n]  = nx[23:0];
          node_cur_y[n]  = ny[23:0];
          // The wall only bites while it is inside the position range, so the
          // truncation to 24 bits below is safe.
          if (nx > wall) begin
            node_cur_x[n]  = wall[23:0];
            node_prev_x[n] = wall[23:0];
          end else if (nx < 0) begin
            node_cur_x[n]  = '0;
            node_prev_x[n] = '0;
          end
          // A node past the floor is left where it is and cut loose.
          if (ny > floor3) begin
            res.disc = 1'b1;
          end else if (ny < 0) begin
            node_cur_y[n]  = '0;
            node_prev_y[n] = '0;
          end
        end
      end
    endcase
    res.pos_x = node_cur_x[n];
    res.pos_y = node_cur_y[n];
    return res;
  endfunction

  // Present one item, optionally after a random idle burst, and wait until it is
  // accepted. The expected result is queued on acceptance.
  task automatic send_item(input node_cmd_t item, input logic typed,
                           input node_result_t typed_res);
    node_result_t predicted;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, item.right, item.left, item.my, item.mx, item.cy, item.cx, item.node};
    in_tuser  <= item.cmd;
    do @(posedge clk); while (!in_tready);
    predicted = integrate_node(item);
    node_results_due.push_back(typed ? typed_res : predicted);
  endtask

  // Rewrite all six registers once the block has drained.
  task automatic write_settings(input logic [15:0] d, input logic [15:0] ts,
                                input logic [23:0] gx, input logic [23:0] gy,
                                input logic [15:0] bw, input logic [15:0] bh);
    logic [2:0]  idx [6];
    logic [23:0] val [6];
    idx = '{CFG_DRAG, CFG_TIME_STEP, CFG_GRAVITY_X, CFG_GRAVITY_Y,
            CFG_BOX_WIDTH, CFG_BOX_HEIGHT};
    val = '{24'(d), 24'(ts), gx, gy, 24'(bw), 24'(bh)};
    in_tvalid <= 1'b0;
    while (node_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    drag_q16 = d;
    step_q16 = ts;
    grav_x   = gx;
    grav_y   = gy;
    box_w    = bw;
    box_h    = bh;
  endtask

  // Mostly positions inside a typical box, sometimes anywhere in the Q16.8 range.
  function automatic logic signed [23:0] random_coord();
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 2400) * 256 + $urandom_range(0, 255));
  endfunction

  // Random command items. They mostly act on a small pool of nodes, so that updates
  // follow each other on the same node. Any command aimed at a node that was never
  // loaded is sent as a load instead.
  task automatic run_random(input int count);
    node_cmd_t item;
    int        n;
    int        pick;
    repeat (count) begin
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 255);
      pick = $urandom_range(0, 19);
      item.node  = 8'(n);
      item.cx    = random_coord();
      item.cy    = random_coord();
      item.left  = 1'($urandom_range(0, 1));
      item.right = 1'($urandom_range(0, 1));
      if (!node_loaded[n] || pick < 2) begin
        item.cmd = CMD_LOAD;
      end else if (pick < 5) begin
        item.cmd = CMD_SET;
      end else if (pick == 5) begin
        item.cmd = CMD_PIN;
      end else begin
        item.cmd = CMD_UPDATE;
      end
      // Half the time the cursor lands within about 40 px of the node, which is
      // inside the selection radius for most offsets.
      if (node_loaded[n] && $urandom_range(0, 1) == 1) begin
        item.mx = 16'(int'(node_cur_x[n] >>> 8) + $urandom_range(0, 80) - 40);
        item.my = 16'(int'(node_cur_y[n] >>> 8) + $urandom_range(0, 80) - 40);
      end else begin
        item.mx = 16'($urandom);
        item.my = 16'($urandom);
      end
      send_item(item, 1'b0, '0);
    end
  endtask

  // The result side stalls in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic signed [23:0] want_v,
                               input logic signed [23:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Checks each result item that the block hands over against the oldest expected one.
  always @(posedge clk) begin
    node_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (node_results_due.size() == 0) begin
        $error("result item for node %0d arrived with no result expected", out_tdata[7:0]);
        fail_count++;
      end else begin
        want = node_results_due.pop_front();
        compare_field("node_out", 24'(want.node), 24'(out_tdata[7:0]));
        compare_field("pos_x", want.pos_x, out_tdata[31:8]);
        compare_field("pos_y", want.pos_y, out_tdata[55:32]);
        compare_field("selected", 24'(want.sel), 24'(out_tdata[56]));
        compare_field("disconnect", 24'(want.disc), 24'(out_tdata[57]));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;

    // The directed table runs under the reset settings.
    foreach (DIRECTED_ROWS[i]) begin
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // No damping, the longest step, gravity at opposite extremes and the largest box.
    write_settings(16'd0, 16'hFFFF, POS_TOP, POS_BOT, 16'hFFFF, 16'hFFFF);
    run_random(90);

    // The heaviest damping, a zero step and a zero box. With a zero box the walls
    // sit at the origin.
    write_settings(16'hFFFF, 16'd0, POS_BOT, POS_TOP, 16'd0, 16'd0);
    run_random(70);

    // Every register takes a random value. Gravity this strong saturates positions.
    write_settings(16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                   16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)));
    run_random(90);

    // Moderate random settings, where nodes mostly stay inside the box.
    write_settings(16'($urandom_range(0, 4000)), 16'($urandom_range(500, 3000)),
                   24'($urandom_range(0, 512000) - 256000),
                   24'($urandom_range(0, 512000) - 256000),
                   16'($urandom_range(200, 2000)), 16'($urandom_range(200, 2000)));
    run_random(110);

    // Back to the reset settings. Both sides run without gaps until the end.
    write_settings(16'd655, 16'd1092, 24'sd0, 24'sd256000, 16'd800, 16'd600);
    idle_on = 1'b0;
    run_random(120);

    in_tvalid <= 1'b0;
    while (node_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
